[design/top_k_similarity_keeper_top_defines.svh]
// assertion macros used by the checker file
`ifndef TOP_K_SIMILARITY_KEEPER_TOP_DEFINES_SVH
`define TOP_K_SIMILARITY_KEEPER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define TKS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tks_pkg.sv]
// shared types and constants of the top-k similarity keeper
package tks_pkg;

    localparam int SCORE_W      = 17;
    localparam int ID_W         = 24;
    localparam int KEEP_W       = 5;
    localparam int OP_W         = 2;
    localparam int MAX_KEEP_DEF = 20;

    localparam logic [SCORE_W-1:0] ONE_Q16        = 17'd65536;
    localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST = 5'd20;
    localparam logic [SCORE_W-1:0] MIN_SCORE_RST  = 17'd1;

    // input opcodes
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic {
        REG_KEEP_COUNT = 1'b0,
        REG_MIN_SCORE  = 1'b1
    } reg_idx_t;

    // command kinds handed from front to back
    typedef enum logic [2:0] {
        CMD_ADD,
        CMD_DROP,
        CMD_READ,
        CMD_CLEAR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    item_id;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]    item_id;
        logic [SCORE_W-1:0] score;
        logic [SCORE_W-1:0] cutoff;
        logic               accepted;
        logic               empty_res;
        logic               last;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } back_state_t;

endpackage

[design/tks_front.sv]
// front end: saturates the score and classifies each input item into a command
module tks_front (
    input  logic [tks_pkg::OP_W-1:0]    opcode,
    input  logic [tks_pkg::SCORE_W-1:0] score,
    input  logic [tks_pkg::ID_W-1:0]    item_id,
    input  logic [tks_pkg::SCORE_W-1:0] min_score,
    output tks_pkg::cmd_t               cmd
);
    import tks_pkg::*;

    logic [SCORE_W-1:0] score_sat;

    // scores above one clip to one
    assign score_sat = (score > ONE_Q16) ? ONE_Q16 : score;

    // classify the item
    always_comb
    begin
        cmd.score   = score_sat;
        cmd.item_id = item_id;
        case (opcode)
            OP_ADD:   cmd.kind = (score_sat < min_score) ? CMD_DROP : CMD_ADD;
            OP_READ:  cmd.kind = CMD_READ;
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            default:  cmd.kind = CMD_NOP;
        endcase
    end

endmodule

[design/tks_queue.sv]
// two-entry command queue between front and back
module tks_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tks_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tks_pkg::cmd_t pop_cmd
);
    import tks_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/tks_back.sv]
// back end: sorted cell list, insert with eviction, readout sequencer, output register
module tks_back #(
    parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pop_valid,
    output logic                       pop_ready,
    input  tks_pkg::cmd_t              pop_cmd,
    input  logic [tks_pkg::KEEP_W-1:0] keep_count,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tks_pkg::res_t              res
);
    import tks_pkg::*;

    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;

    logic [SCORE_W-1:0] score_reg [MAX_KEEP];
    logic [SCORE_W-1:0] score_next [MAX_KEEP];
    logic [ID_W-1:0]    id_reg [MAX_KEEP];
    logic [ID_W-1:0]    id_next [MAX_KEEP];
    logic [SCORE_W-1:0] up_score [MAX_KEEP];
    logic [SCORE_W-1:0] dn_score [MAX_KEEP];
    logic [ID_W-1:0]    up_id [MAX_KEEP];
    logic [ID_W-1:0]    dn_id [MAX_KEEP];

    logic [CW-1:0]      count_reg, count_next, count_m1;
    logic [SCORE_W-1:0] cutoff_reg, cutoff_next;
    logic [IW-1:0]      idx_reg, idx_next, rd_idx;
    back_state_t        state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg, res_next;

    logic [MAX_KEEP:0]  le_ext;
    logic [MAX_KEEP-1:0] prev_le;
    logic [LW-1:0]      keep_ext, lim, count_ext;
    logic               full, advance, do_add;

    // per-cell compare and neighbor taps
    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        assign le_ext[i] = (CW'(i) < count_reg) && (score_reg[i] <= pop_cmd.score);
        if (i + 1 < MAX_KEEP)
        begin : g_up
            assign up_score[i] = score_reg[i+1];
            assign up_id[i]    = id_reg[i+1];
        end
        else
        begin : g_up_end
            assign up_score[i] = '0;
            assign up_id[i]    = '0;
        end
        if (i > 0)
        begin : g_dn
            assign dn_score[i] = score_reg[i-1];
            assign dn_id[i]    = id_reg[i-1];
            assign prev_le[i]  = le_ext[i-1];
        end
        else
        begin : g_dn_end
            assign dn_score[i] = '0;
            assign dn_id[i]    = '0;
            assign prev_le[i]  = 1'b1;
        end
    end
    assign le_ext[MAX_KEEP] = 1'b0;

    // effective limit and eviction due
    assign keep_ext  = LW'(keep_count);
    assign count_ext = LW'(count_reg);
    assign lim       = (keep_ext == '0) ? LW'(1) :
                       (keep_ext > LW'(MAX_KEEP)) ? LW'(MAX_KEEP) : keep_ext;
    assign full      = (count_ext >= lim);

    assign advance   = !out_valid_reg || res_ready;
    assign pop_ready = (state_reg == ST_IDLE) && advance;
    assign do_add    = pop_valid && pop_ready && (pop_cmd.kind == CMD_ADD);
    assign count_m1  = count_reg - CW'(1);
    assign rd_idx    = (state_reg == ST_IDLE) ? count_m1[IW-1:0] : idx_reg;

    // cell next values: shift down on eviction, shift up on growth
    always_comb
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_next[i] = score_reg[i];
            id_next[i]    = id_reg[i];
            if (do_add)
            begin
                if (full)
                begin
                    if (le_ext[i] && le_ext[i+1])
                    begin
                        score_next[i] = up_score[i];
                        id_next[i]    = up_id[i];
                    end
                    else if (le_ext[i])
                    begin
                        score_next[i] = pop_cmd.score;
                        id_next[i]    = pop_cmd.item_id;
                    end
                end
                else if (!le_ext[i] && prev_le[i])
                begin
                    score_next[i] = pop_cmd.score;
                    id_next[i]    = pop_cmd.item_id;
                end
                else if (!le_ext[i])
                begin
                    score_next[i] = dn_score[i];
                    id_next[i]    = dn_id[i];
                end
            end
        end
    end

    // sequencer: next state, counters and result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        cutoff_next    = cutoff_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid && advance)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.last  = 1'b1;
                    case (pop_cmd.kind)
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                cutoff_next = score_next[0];
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                            res_next.accepted = !full || le_ext[0];
                        end
                        CMD_CLEAR:
                        begin
                            count_next  = '0;
                            cutoff_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.empty_res = 1'b1;
                            end
                            else
                            begin
                                res_next.item_id = id_reg[rd_idx];
                                res_next.score   = score_reg[rd_idx];
                                res_next.last    = (count_reg == CW'(1));
                                if (count_reg != CW'(1))
                                begin
                                    idx_next   = rd_idx - IW'(1);
                                    state_next = ST_READOUT;
                                end
                            end
                        end
                        default:
                        begin
                            res_next.last = 1'b1;
                        end
                    endcase
                    res_next.cutoff = cutoff_next;
                end
            end
            ST_READOUT:
            begin
                if (advance)
                begin
                    out_valid_next   = 1'b1;
                    res_next         = '0;
                    res_next.item_id = id_reg[rd_idx];
                    res_next.score   = score_reg[rd_idx];
                    res_next.cutoff  = cutoff_reg;
                    res_next.last    = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            cutoff_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            cutoff_reg    <= cutoff_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // list cells and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            score_reg[i] <= score_next[i];
            id_reg[i]    <= id_next[i];
        end
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[design/top_k_similarity_keeper_top.sv]
// top level of the top-k similarity keeper
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser opcode, tdata score, item_id
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata id, score, cutoff; tuser flags; tlast
// cfg      in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// add, clear and unknown opcodes give one result each from the back end; a readout gives
// one result per kept pair, or one empty result, through the single read port of the cell list.
// the front takes an item per cycle into a two-entry queue with room while the back is busy.
// reset empties the list and zeroes the cutoff at once; no clearing pass.
// a stalled m_axis holds its result and the back end; s_axis stalls once the queue is full.
module top_k_similarity_keeper_top #(
    parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [47:0]                 s_axis_tdata,   // score[16:0], item_id[40:17]
    input  logic [tks_pkg::OP_W-1:0]    s_axis_tuser,   // opcode[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,   // out_item_id[23:0], out_score[40:24],
                                                        // cutoff[57:41]
    output logic [1:0]                  m_axis_tuser,   // accepted[0], empty_res[1]
    output logic                        m_axis_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [tks_pkg::SCORE_W-1:0] cfg_data
);
    import tks_pkg::*;

    logic [KEEP_W-1:0]  keep_count_reg;
    logic [SCORE_W-1:0] min_score_reg;
    cmd_t               front_cmd, queue_cmd;
    logic               queue_valid, queue_ready;
    res_t               res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_COUNT_RST;
            min_score_reg  <= MIN_SCORE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_KEEP_COUNT: keep_count_reg <= cfg_data[KEEP_W-1:0];
                REG_MIN_SCORE:  min_score_reg  <= cfg_data;
                default:        keep_count_reg <= keep_count_reg;
            endcase
        end
    end

    // classify
    tks_front u_front (
        .opcode    (s_axis_tuser),
        .score     (s_axis_tdata[SCORE_W-1:0]),
        .item_id   (s_axis_tdata[SCORE_W+ID_W-1:SCORE_W]),
        .min_score (min_score_reg),
        .cmd       (front_cmd)
    );

    // decoupling queue
    tks_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    // execute
    tks_back #(
        .MAX_KEEP (MAX_KEEP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd),
        .keep_count (keep_count_reg),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // pack the result
    assign m_axis_tdata = {6'd0, res.cutoff, res.score, res.item_id};
    assign m_axis_tuser = {res.empty_res, res.accepted};
    assign m_axis_tlast = res.last;

endmodule

[design/tks_checker.sv]
// port-level checker for the top-k similarity keeper, with its bind
`include "top_k_similarity_keeper_top_defines.svh"

module tks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds still
    `TKS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed under stall")

    // an empty readout is a single final item with no pair in it
    `TKS_ASSERT_IMPLY(a_empty_single, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && (m_axis_tdata[40:0] == 41'd0) && !m_axis_tuser[0], "empty readout malformed")

    // an accepted add answer carries no pair and ends its run
    `TKS_ASSERT_IMPLY(a_accept_shape, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata[40:0] == 41'd0), "accepted result malformed")

    // cutoff and read scores never exceed one
    `TKS_ASSERT_IMPLY(a_score_range, m_axis_tvalid, (m_axis_tdata[57:41] <= 17'd65536) && (m_axis_tdata[40:24] <= 17'd65536), "score out of range")

endmodule

bind top_k_similarity_keeper_top tks_checker u_tks_checker (.*);

[test/top_k_similarity_keeper_top_tb.sv]
// self-checking testbench for the top-k similarity keeper top level
module top_k_similarity_keeper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tks_pkg::*;

    localparam int          KEEP_DEPTH  = MAX_KEEP_DEF;
    localparam logic [1:0]  OP_UNKNOWN  = 2'd3;
    localparam int          HOLD_CYCLES = 80;
    localparam int          LIMIT       = 500000;
    localparam int          REPORT_MAX  = 10;

    // scoreboard: sorted-list predictor plus queue of expected results
    class topk_scoreboard;
        logic [SCORE_W-1:0] lst_score [KEEP_DEPTH];
        logic [ID_W-1:0]    lst_id    [KEEP_DEPTH];
        int                 lst_n;
        logic [SCORE_W-1:0] cut;
        logic [KEEP_W-1:0]  keep_reg;
        logic [SCORE_W-1:0] floor_reg;
        res_t               pending_q [$];
        int                 mismatches;

        function new();
            lst_n      = 0;
            cut        = '0;
            keep_reg   = KEEP_COUNT_RST;
            floor_reg  = MIN_SCORE_RST;
            mismatches = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [SCORE_W-1:0] val);
            if (idx == REG_KEEP_COUNT)
                keep_reg = val[KEEP_W-1:0];
            else
                floor_reg = val;
        endfunction

        // append one expected result
        function void queue_result(res_t r);
            pending_q = {pending_q, r};
        endfunction

        // sorted insert with eviction of the smallest, oldest pair
        function bit insert_pair(logic [SCORE_W-1:0] s_in, logic [ID_W-1:0] id);
            logic [SCORE_W-1:0] s;
            int                 lim;
            int                 p;
            int                 i;
            s = (s_in > ONE_Q16) ? ONE_Q16 : s_in;
            if (s < floor_reg)
                return 1'b0;
            lim = int'(keep_reg);
            if (lim == 0)
                lim = 1;
            if (lim > KEEP_DEPTH)
                lim = KEEP_DEPTH;
            p = 0;
            while (p < lst_n && lst_score[p] <= s)
                p++;
            if (lst_n + 1 > lim)
            begin
                if (p == 0)
                begin
                    cut = lst_score[0];
                    return 1'b0;
                end
                for (i = 0; i + 1 < p; i++)
                begin
                    lst_score[i] = lst_score[i+1];
                    lst_id[i]    = lst_id[i+1];
                end
                lst_score[p-1] = s;
                lst_id[p-1]    = id;
                cut            = lst_score[0];
                return 1'b1;
            end
            for (i = lst_n; i > p; i--)
            begin
                lst_score[i] = lst_score[i-1];
                lst_id[i]    = lst_id[i-1];
            end
            lst_score[p] = s;
            lst_id[p]    = id;
            lst_n++;
            return 1'b1;
        endfunction

        // work out the results of one accepted item
        function void note_item(logic [1:0] op, logic [SCORE_W-1:0] sc, logic [ID_W-1:0] id);
            res_t r;
            int   k;
            bit   took;
            r = '0;
            case (op)
                OP_ADD:
                begin
                    took       = insert_pair(sc, id);
                    r.cutoff   = cut;
                    r.accepted = took;
                    r.last     = 1'b1;
                    queue_result(r);
                end
                OP_READ:
                begin
                    if (lst_n == 0)
                    begin
                        r.cutoff    = cut;
                        r.empty_res = 1'b1;
                        r.last      = 1'b1;
                        queue_result(r);
                    end
                    else
                    begin
                        for (k = lst_n - 1; k >= 0; k--)
                        begin
                            r         = '0;
                            r.item_id = lst_id[k];
                            r.score   = lst_score[k];
                            r.cutoff  = cut;
                            r.last    = (k == 0);
                            queue_result(r);
                        end
                    end
                end
                OP_CLEAR:
                begin
                    lst_n  = 0;
                    cut    = '0;
                    r.last = 1'b1;
                    queue_result(r);
                end
                default:
                begin
                    r.cutoff = cut;
                    r.last   = 1'b1;
                    queue_result(r);
                end
            endcase
        endfunction

        // compare one result with the oldest expectation
        function void check_result(res_t got);
            res_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: id=%h score=%h cut=%h acc=%b emp=%b last=%b",
                             got.item_id, got.score, got.cutoff, got.accepted,
                             got.empty_res, got.last);
                return;
            end
            want = pending_q.pop_front();
            if (got.item_id !== want.item_id || got.score !== want.score ||
                got.cutoff !== want.cutoff || got.accepted !== want.accepted ||
                got.empty_res !== want.empty_res || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch exp: id=%h score=%h cut=%h acc=%b emp=%b last=%b",
                             want.item_id, want.score, want.cutoff, want.accepted,
                             want.empty_res, want.last);
                    $display("         got: id=%h score=%h cut=%h acc=%b emp=%b last=%b",
                             got.item_id, got.score, got.cutoff, got.accepted,
                             got.empty_res, got.last);
                end
            end
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata;
    logic [OP_W-1:0]    s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [63:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               m_axis_tlast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [SCORE_W-1:0] cfg_data;

    topk_scoreboard sb;
    bit             hold_req;
    int             cycle_cnt;

    top_k_similarity_keeper_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // watchdog
    initial cycle_cnt = 0;
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.item_id   = m_axis_tdata[23:0];
            got.score     = m_axis_tdata[40:24];
            got.cutoff    = m_axis_tdata[57:41];
            got.accepted  = m_axis_tuser[0];
            got.empty_res = m_axis_tuser[1];
            got.last      = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        mode          = 0;
        mode_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = ($urandom_range(0, 99) >= 30);
                    2: m_axis_tready = ~m_axis_tready;
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // offer one item and wait until it is taken
    task automatic offer(logic [1:0] op, logic [SCORE_W-1:0] sc, logic [ID_W-1:0] id);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, id, sc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(op, sc, id);
    endtask

    // sender gap, with s_axis_tvalid held low
    task automatic pause(int n);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending and wait until every expected result has come
    task automatic drain(int extra);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [SCORE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly adds, scores often on a coarse grid to force ties
    task automatic pick_item(output logic [1:0] op, output logic [SCORE_W-1:0] sc,
                             output logic [ID_W-1:0] id);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80 || r >= 98)
            op = OP_ADD;
        else if (r < 92)
            op = OP_READ;
        else if (r < 95)
            op = OP_CLEAR;
        else
            op = OP_UNKNOWN;
        r = $urandom_range(0, 9);
        if (r < 4)
            sc = SCORE_W'($urandom_range(0, 8) * 8192);
        else if (r < 8)
            sc = SCORE_W'($urandom_range(0, 65536));
        else if (r == 8)
            sc = SCORE_W'($urandom_range(65537, 131071));
        else
            sc = ($urandom_range(0, 1) == 1) ? ONE_Q16 : SCORE_W'($urandom_range(0, 1));
        id = ID_W'($urandom);
    endtask

    // random items in bursts with gaps; optionally start under a receiver hold-off
    task automatic run_phase(int n, bit squeeze);
        int                 left;
        int                 burst;
        logic [1:0]         op;
        logic [SCORE_W-1:0] sc;
        logic [ID_W-1:0]    id;
        left = n;
        if (squeeze)
        begin
            hold_req = 1'b1;
            repeat (14)
            begin
                pick_item(op, sc, id);
                offer(op, sc, id);
                left--;
            end
        end
        while (left > 0)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            while (burst > 0 && left > 0)
            begin
                pick_item(op, sc, id);
                offer(op, sc, id);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    // stimulus
    initial
    begin
        int                 keep_set [7];
        int                 floor_set[7];
        int                 count_set[7];
        int                 ph;
        sb            = new();
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        cfg_valid     = 1'b0;
        cfg_index     = REG_KEEP_COUNT;
        cfg_data      = '0;
        keep_set  = '{20, 3, 1, 31, 0, 4, 5};
        floor_set = '{1, 0, 65536, 40000, 0, 30000, 131071};
        count_set = '{60, 40, 30, 50, 30, 50, 12};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset settings, empty readout, extremes, ties, unknown opcode
        offer(OP_READ, '0, '0);
        offer(OP_ADD, 17'd0, 24'h000001);
        offer(OP_ADD, 17'd1, 24'h000000);
        offer(OP_ADD, ONE_Q16, 24'hFFFFFF);
        offer(OP_ADD, 17'h1FFFF, 24'h123456);
        offer(OP_ADD, 17'd500, 24'h00000A);
        offer(OP_ADD, 17'd500, 24'h00000B);
        offer(OP_UNKNOWN, 17'h1FFFF, 24'hFFFFFF);
        offer(OP_READ, '0, '0);
        offer(OP_CLEAR, '0, '0);
        offer(OP_READ, '0, '0);
        drain(6);

        // directed: two-entry list, eviction of the new pair and of the oldest tie
        write_reg(REG_KEEP_COUNT, 17'd2);
        write_reg(REG_MIN_SCORE, 17'd0);
        offer(OP_ADD, 17'd0, 24'hABCDEF);
        offer(OP_ADD, 17'd100, 24'h000100);
        offer(OP_ADD, 17'd200, 24'h000200);
        offer(OP_ADD, 17'd50, 24'h000050);
        offer(OP_ADD, 17'd100, 24'h000101);
        offer(OP_READ, '0, '0);
        offer(OP_ADD, 17'd300, 24'h000300);
        offer(OP_READ, '0, '0);
        offer(OP_CLEAR, '0, '0);
        offer(OP_READ, '0, '0);
        drain(6);

        // random phases across settings, keep count lowered on a full list
        for (ph = 0; ph < 7; ph++)
        begin
            write_reg(REG_KEEP_COUNT, SCORE_W'(keep_set[ph]));
            write_reg(REG_MIN_SCORE, SCORE_W'(floor_set[ph]));
            run_phase(count_set[ph], ph == 3);
            drain(6);
        end

        drain(30);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
